// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps
package skt_pkg;

    localparam int KEY_W    = 64;
    localparam int OFF_W    = 32;
    localparam int LEN_W    = 24;
    localparam int STAT_W   = 3;
    localparam int POS_W    = 10;
    localparam int DEPTH_DEF = 1024;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_entry;

    // per-leaf match data carried up the reduction tree
    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_hit;

    // node count of a radix-4 tree level
    function automatic int lvl_cnt(input int n, input int l);
        int c;
        c = n;
        for (int i = 0; i < l; i++) begin
            c = (c + 3) >> 2;
        end
        return c;
    endfunction

    function automatic int tree_levels(input int n);
        int c;
        int l;
        c = n;
        l = 0;
        while (c > 1) begin
            c = (c + 3) >> 2;
            l++;
        end
        return l;
    endfunction

endpackage

// ===== rtl/skt_cell.sv =====
`timescale 1ns / 1ps
module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 11
) (
    input  logic          i_clk,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_new,
    input  t_entry        i_prev,
    input  logic          i_prev_lt,
    input  logic          i_ins,
    output t_entry        o_entry,
    output logic          o_lt,
    output logic          o_sel,
    output t_hit          o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_valid;
    logic   w_eq;

    assign w_valid = (i_count > CW'(IDX));
    assign o_lt    = w_valid && (r_entry.key < i_key);
    assign w_eq    = w_valid && (r_entry.key == i_key);
    // first cell whose key is not below the probe: the lower bound
    assign o_sel   = !o_lt && i_prev_lt;

    assign o_hit.hit = o_sel && w_eq;
    assign o_hit.off = (o_sel && w_eq) ? r_entry.off : '0;
    assign o_hit.len = (o_sel && w_eq) ? r_entry.len : '0;
    assign o_entry   = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ins && o_sel) begin
            n_entry = i_new;
        end else if (i_ins && !o_lt) begin
            n_entry = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/skt_tree.sv =====
`timescale 1ns / 1ps
module skt_tree
    import skt_pkg::*;
#(
    parameter int N  = 1025,
    parameter int PW = 11
) (
    input  logic          i_clk,
    input  logic [PW-1:0] i_pos [N],
    input  t_hit          i_hit [N],
    output logic [PW-1:0] o_pos,
    output t_hit          o_hit
);

    localparam int L = tree_levels(N);

    logic [PW-1:0] r_pos [0:L][0:N-1];
    t_hit          r_hit [0:L][0:N-1];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N; j++) begin
            r_pos[0][j] <= i_pos[j];
            r_hit[0][j] <= i_hit[j];
        end
    end

    // one-hot inputs, so an OR reduction selects the single active leaf
    for (genvar l = 0; l < L; l++) begin : g_lvl
        localparam int CI = lvl_cnt(N, l);
        localparam int CO = lvl_cnt(N, l + 1);
        for (genvar j = 0; j < CO; j++) begin : g_node
            logic [PW-1:0] w_pos [4];
            t_hit          w_hit [4];
            for (genvar k = 0; k < 4; k++) begin : g_in
                if (4 * j + k < CI) begin : g_use
                    assign w_pos[k] = r_pos[l][4*j+k];
                    assign w_hit[k] = r_hit[l][4*j+k];
                end else begin : g_pad
                    assign w_pos[k] = '0;
                    assign w_hit[k] = '0;
                end
            end
            always_ff @(posedge i_clk) begin
                r_pos[l+1][j] <= w_pos[0] | w_pos[1] | w_pos[2] | w_pos[3];
                r_hit[l+1][j] <= w_hit[0] | w_hit[1] | w_hit[2] | w_hit[3];
            end
        end
    end

    assign o_pos = r_pos[L][0];
    assign o_hit = r_hit[L][0];

endmodule

// ===== rtl/sorted_key_table_top.sv =====
`timescale 1ns / 1ps
// Sorted key table: up to DEPTH entries kept in ascending key order, one entry
// per cell in a row of cells.
// Command channel: drive i_func, i_key, i_str_offset, i_str_length with start
// high; the item is taken on the edge where start is high and busy is low.
// Result channel: o_valid is high for exactly one cycle with o_status,
// o_position, o_entry_offset and o_entry_length; the receiver cannot stall,
// so it must capture the result in that cycle.
// Every cell compares its key with the command key in parallel; the lower
// bound and the matching entry are gathered by a registered radix-4 OR tree
// of L = ceil(log4(DEPTH+1)) levels. On insert the lower-bound cell takes the
// new entry and each cell above it its lower neighbor's entry in the same cycle.
// The command register feeds the cells, whose results pass through the leaf
// register and each tree level; the result registers and o_valid are loaded as
// busy drops, so a new item is taken only once the last one's result is out.
// Reset (i_rst_n low, synchronous) empties the table and drops busy and
// o_valid; cell contents are left as they are and only count as valid once
// written.
module sorted_key_table_top
    import skt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [OFF_W-1:0]  i_str_offset,
    input  logic [LEN_W-1:0]  i_str_length,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [POS_W-1:0]  o_position,
    output logic [OFF_W-1:0]  o_entry_offset,
    output logic [LEN_W-1:0]  o_entry_length
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = CW;
    localparam int N   = DEPTH + 1;
    localparam int L   = tree_levels(N);
    localparam int LAT = L + 1;
    localparam int SW  = $clog2(LAT + 1);

    logic          r_busy;
    logic [SW-1:0] r_stg;
    logic [CW-1:0] r_count;
    logic          r_func;
    t_entry        r_cmd;

    t_entry        w_entry [DEPTH];
    logic          w_lt    [DEPTH];
    logic          w_sel   [DEPTH];
    logic [PW-1:0] w_pos   [N];
    t_hit          w_hit   [N];
    logic [PW-1:0] w_root_pos;
    t_hit          w_root_hit;

    logic                  w_done;
    logic                  w_full;
    logic                  w_ins;
    logic [STAT_W-1:0]     n_status;
    logic [OFF_W-1:0]      n_off;
    logic [LEN_W-1:0]      n_len;
    logic [PW+POS_W-1:0]   w_pos_ext;

    assign busy = r_busy;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_lt;
        if (j == 0) begin : g_first
            assign w_prev    = r_cmd;
            assign w_prev_lt = 1'b1;
        end else begin : g_rest
            assign w_prev    = w_entry[j-1];
            assign w_prev_lt = w_lt[j-1];
        end
        skt_cell #(
            .IDX (j),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_key     (r_cmd.key),
            .i_count   (r_count),
            .i_new     (r_cmd),
            .i_prev    (w_prev),
            .i_prev_lt (w_prev_lt),
            .i_ins     (w_ins),
            .o_entry   (w_entry[j]),
            .o_lt      (w_lt[j]),
            .o_sel     (w_sel[j]),
            .o_hit     (w_hit[j])
        );
        assign w_pos[j] = w_sel[j] ? PW'(j) : '0;
    end

    // lower bound past the last cell: table full and every key below
    assign w_pos[DEPTH] = w_lt[DEPTH-1] ? PW'(DEPTH) : '0;
    assign w_hit[DEPTH] = '0;

    skt_tree #(
        .N  (N),
        .PW (PW)
    ) u_tree (
        .i_clk (i_clk),
        .i_pos (w_pos),
        .i_hit (w_hit),
        .o_pos (w_root_pos),
        .o_hit (w_root_hit)
    );

    assign w_done    = r_busy && (r_stg == SW'(LAT));
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_ins     = w_done && (r_func == FUNC_INSERT) && !w_root_hit.hit && !w_full;
    assign w_pos_ext = {{POS_W{1'b0}}, w_root_pos};

    always_comb begin
        n_off = '0;
        n_len = '0;
        if (r_func == FUNC_LOOKUP) begin
            n_status = w_root_hit.hit ? ST_FOUND : ST_MISSING;
        end else if (w_root_hit.hit) begin
            n_status = ST_PRESENT;
        end else if (w_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_INSERTED;
            n_off    = r_cmd.off;
            n_len    = r_cmd.len;
        end
        if (w_root_hit.hit) begin
            n_off = w_root_hit.off;
            n_len = w_root_hit.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_stg   <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_done;
            if (start && !r_busy) begin
                r_busy <= 1'b1;
                r_stg  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_stg <= r_stg + 1'b1;
            end
            if (w_ins) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_func    <= i_func;
            r_cmd.key <= i_key;
            r_cmd.off <= i_str_offset;
            r_cmd.len <= i_str_length;
        end
        if (w_done) begin
            o_status       <= n_status;
            o_position     <= w_pos_ext[POS_W-1:0];
            o_entry_offset <= n_off;
            o_entry_length <= n_len;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !r_busy)
        else $error("result strobe while still busy");

    a_count_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) && $past(i_rst_n) |->
            o_valid && (o_status == ST_INSERTED))
        else $error("count changed without an insert");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !r_busy |=> r_busy && (r_stg == '0))
        else $error("accepted item did not start");

endmodule
